### rtl/core/frame_animation_sequencer_core_assert.svh
// Assertion macros for the frame animation sequencer core.
// Used by files that hold concurrent checks; expects clk and rst_n in scope.
`ifndef FRAME_ANIMATION_SEQUENCER_CORE_ASSERT_SVH
`define FRAME_ANIMATION_SEQUENCER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check disabled while reset is asserted.
`define FAS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("frame sequencer check failed");

// Check that also holds across reset.
`define FAS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("frame sequencer reset check failed");

`else

`define FAS_ASSERT(lbl, prop)
`define FAS_ASSERT_RST(lbl, prop)

`endif

`endif

### rtl/core/fas_pkg.sv
// Shared constants, codes and types of the frame animation sequencer.
// No dependencies; imported by every other file of the block but the assertion header.
`timescale 1ns / 1ps
`default_nettype none

package fas_pkg;

  localparam int MAX_FRAMES    = 16;
  localparam int DURATION_BITS = 8;

  localparam int IDX_W   = $clog2(MAX_FRAMES);
  localparam int SUM_W   = DURATION_BITS + IDX_W;
  localparam int POS_W   = 12;
  localparam int CMP_W   = (SUM_W > POS_W) ? SUM_W : POS_W;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Port field widths
  localparam int OP_W      = 2;
  localparam int EIDX_W    = 4;
  localparam int ETICK_W   = 8;
  localparam int FRAME_W   = 4;
  localparam int FC_W      = 5;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_RESTART = 2'd1,
    OP_WRITE   = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PINGPONG = 2'd0,
    MODE_LOOP     = 2'd1,
    MODE_ONCE     = 2'd2,
    MODE_STOP     = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COUNT = 1'b0,
    CFG_END_MODE    = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } seq_state_t;

  // Control from the sequencer to the accumulate/compare unit
  typedef struct packed {
    logic clr;
    logic add;
  } acc_ctrl_t;

  // Status back from the accumulate/compare unit
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] total_sat;
  } acc_stat_t;

endpackage

`default_nettype wire

### rtl/core/fas_in_if.sv
// Input channel of the frame animation sequencer: valid/ready plus op fields.
// Depends on fas_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface fas_in_if
  import fas_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [EIDX_W-1:0]    entry_index;
  logic [ETICK_W-1:0]   entry_ticks;

  modport source (output valid, output opcode, output entry_index, output entry_ticks,
                  input ready);
  modport sink   (input valid, input opcode, input entry_index, input entry_ticks,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/fas_out_if.sv
// Result channel of the frame animation sequencer: valid/ready plus status.
// Depends on fas_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface fas_out_if
  import fas_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [FRAME_W-1:0]  current_frame;
  logic                anim_ended;
  logic                playing_backward;
  logic [POS_W-1:0]    tick_position;

  modport source (output valid, output current_frame, output anim_ended,
                  output playing_backward, output tick_position, input ready);
  modport sink   (input valid, input current_frame, input anim_ended,
                  input playing_backward, input tick_position, output ready);
endinterface

`default_nettype wire

### rtl/core/frame_animation_sequencer_core.sv
// A tick walks the duration table in the single accumulate/compare unit, one table entry
// per cycle, until it reaches the frame that holds the position or the last frame of the
// clamped frame count (1..16 frames); restart, write and no-op go straight to the result.
// No new input is taken until the result is loaded into the output register, and a result
// still held on the output stalls that load, and so the next input transfer, until it drains.
// Reset: synchronous, active low; clears position, frame, flags and config to
// frame_count 1, loop mode. The duration table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "frame_animation_sequencer_core_assert.svh"

module frame_animation_sequencer_core
  import fas_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  fas_in_if.sink                     in_chan,
  fas_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [FC_W-1:0]   frame_count_r;
  logic [MODE_W-1:0] end_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FC_W'(1);
      end_mode_r    <= MODE_LOOP;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_COUNT: frame_count_r <= FC_W'(cfg_data);
        CFG_END_MODE:    end_mode_r    <= cfg_data[MODE_W-1:0];
        default:         end_mode_r    <= end_mode_r;
      endcase
    end
  end

  fas_seq u_seq (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_chan.valid),
    .in_ready             (in_chan.ready),
    .in_opcode            (in_chan.opcode),
    .in_entry_index       (in_chan.entry_index),
    .in_entry_ticks       (in_chan.entry_ticks),
    .frame_count          (frame_count_r),
    .end_mode             (end_mode_r),
    .out_valid            (out_chan.valid),
    .out_ready            (out_chan.ready),
    .out_current_frame    (out_chan.current_frame),
    .out_anim_ended       (out_chan.anim_ended),
    .out_playing_backward (out_chan.playing_backward),
    .out_tick_position    (out_chan.tick_position)
  );

  // Not ready in the cycle after every input transfer
  `FAS_ASSERT(a_busy_after_accept, (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
  // A new result only appears out of a busy cycle
  `FAS_ASSERT(a_result_from_busy, $rose(out_chan.valid) |-> !$past(in_chan.ready))
  // Reset empties the result register
  `FAS_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_chan.valid)

endmodule

`default_nettype wire

### rtl/core/fas_dur_mem.sv
// Frame duration table: one write port, one registered read port.
// Depends on fas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fas_dur_mem
  import fas_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [IDX_W-1:0]         waddr,
  input  wire logic [DURATION_BITS-1:0] wdata,
  input  wire logic [IDX_W-1:0]         raddr,
  output logic      [DURATION_BITS-1:0] rdata
);

  logic [DURATION_BITS-1:0] mem [MAX_FRAMES];
  logic [DURATION_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/fas_accum.sv
// Shared accumulate and compare unit: running duration total versus position.
// Depends on fas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fas_accum
  import fas_pkg::*;
(
  input  wire logic                     clk,
  input  wire acc_ctrl_t                ctrl,
  input  wire logic [DURATION_BITS-1:0] dur,
  input  wire logic [POS_W-1:0]         pos,
  output acc_stat_t                     stat
);

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic [SUM_W-1:0] sum_add;

  assign sum_add = sum_r + SUM_W'(dur);

  always_comb begin
    sum_nxt = sum_r;
    if (ctrl.clr) begin
      sum_nxt = '0;
    end else if (ctrl.add) begin
      sum_nxt = sum_add;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  // hit: position falls inside the frame just added
  always_comb begin
    stat.hit = CMP_W'(pos) < CMP_W'(sum_add);
    if (CMP_W'(sum_add) > CMP_W'(POS_MAX)) begin
      stat.total_sat = POS_MAX;
    end else begin
      stat.total_sat = POS_W'(sum_add);
    end
  end

endmodule

`default_nettype wire

### rtl/core/fas_seq.sv
// Sequencer of the frame animation core: op decode, frame walk, state, result register.
// Depends on fas_pkg, fas_dur_mem and fas_accum.
`timescale 1ns / 1ps
`default_nettype none

module fas_seq
  import fas_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [OP_W-1:0]       in_opcode,
  input  wire logic [EIDX_W-1:0]     in_entry_index,
  input  wire logic [ETICK_W-1:0]    in_entry_ticks,
  input  wire logic [FC_W-1:0]       frame_count,
  input  wire logic [MODE_W-1:0]     end_mode,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [FRAME_W-1:0]         out_current_frame,
  output logic                       out_anim_ended,
  output logic                       out_playing_backward,
  output logic [POS_W-1:0]           out_tick_position
);

  seq_state_t state_r, state_nxt;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] frame_r, frame_nxt;
  logic             rev_r, rev_nxt;
  logic             end_r, end_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic             out_valid_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic             out_end_r;
  logic             out_rev_r;
  logic [POS_W-1:0] out_pos_r;

  logic             accept;
  logic             out_load;
  logic [IDX_W-1:0] last_idx;
  logic             entry_ok;

  logic                     mem_we;
  logic [IDX_W-1:0]         mem_raddr;
  logic [DURATION_BITS-1:0] mem_rdata;
  acc_ctrl_t                acc_ctrl;
  acc_stat_t                acc_stat;

  op_t   op;
  mode_t mode;

  assign op       = op_t'(in_opcode);
  assign mode     = mode_t'(end_mode);
  assign accept   = in_valid && in_ready;
  assign entry_ok = int'(in_entry_index) < MAX_FRAMES;

  // Active frame count clamped to 1..MAX_FRAMES, as a last index
  always_comb begin
    if (frame_count == '0) begin
      last_idx = '0;
    end else if (int'(frame_count) > MAX_FRAMES) begin
      last_idx = IDX_W'(MAX_FRAMES - 1);
    end else begin
      last_idx = IDX_W'(frame_count - FC_W'(1));
    end
  end

  fas_dur_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (IDX_W'(in_entry_index)),
    .wdata (DURATION_BITS'(in_entry_ticks)),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fas_accum u_accum (
    .clk  (clk),
    .ctrl (acc_ctrl),
    .dur  (mem_rdata),
    .pos  (pos_r),
    .stat (acc_stat)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (op == OP_TICK) ? S_WALK : S_DONE;
        end
      end
      S_WALK: begin
        if (acc_stat.hit || (idx_r == last_idx)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs; the table read runs one entry ahead of the accumulator
  always_comb begin
    in_ready     = 1'b0;
    acc_ctrl.clr = 1'b0;
    acc_ctrl.add = 1'b0;
    mem_raddr    = '0;
    mem_we       = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        acc_ctrl.clr = 1'b1;
        mem_we       = accept && (op == OP_WRITE) && entry_ok;
      end
      S_WALK: begin
        acc_ctrl.add = 1'b1;
        mem_raddr    = idx_r + IDX_W'(1);
      end
      S_DONE: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Animation state update
  always_comb begin
    pos_nxt   = pos_r;
    frame_nxt = frame_r;
    rev_nxt   = rev_r;
    end_nxt   = end_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          case (op)
            OP_TICK: begin
              if (rev_r) begin
                if (pos_r == '0) begin
                  rev_nxt = 1'b0;
                end else begin
                  pos_nxt = pos_r - POS_W'(1);
                end
              end else if (pos_r != POS_MAX) begin
                pos_nxt = pos_r + POS_W'(1);
              end
            end
            OP_RESTART: begin
              pos_nxt   = '0;
              frame_nxt = '0;
              rev_nxt   = 1'b0;
              end_nxt   = 1'b0;
            end
            default: begin
              pos_nxt = pos_r;
            end
          endcase
        end
      end
      S_WALK: begin
        if (acc_stat.hit) begin
          frame_nxt = idx_r;
        end else if (idx_r == last_idx) begin
          // position lies past the end of the animation
          case (mode)
            MODE_PINGPONG: begin
              rev_nxt   = 1'b1;
              pos_nxt   = acc_stat.total_sat;
              frame_nxt = last_idx;
            end
            MODE_LOOP: begin
              pos_nxt   = '0;
              frame_nxt = '0;
            end
            MODE_ONCE: begin
              pos_nxt   = acc_stat.total_sat;
              frame_nxt = last_idx;
              end_nxt   = 1'b1;
            end
            default: begin
              frame_nxt = '0;
              end_nxt   = 1'b1;
            end
          endcase
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      frame_r     <= '0;
      rev_r       <= 1'b0;
      end_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      frame_r <= frame_nxt;
      rev_r   <= rev_nxt;
      end_r   <= end_nxt;
      idx_r   <= idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_frame_r <= FRAME_W'(frame_r);
      out_end_r   <= end_r;
      out_rev_r   <= rev_r;
      out_pos_r   <= pos_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_current_frame    = out_frame_r;
  assign out_anim_ended       = out_end_r;
  assign out_playing_backward = out_rev_r;
  assign out_tick_position    = out_pos_r;

endmodule

`default_nettype wire

### verif/tb_frame_animation_sequencer_core.sv
// Self-checking testbench for frame_animation_sequencer_core: directed ops, end modes
// and random play phases, checked against an in-bench sequencer model.
// Depends on fas_pkg, fas_in_if, fas_out_if and the core RTL.
`timescale 1ns / 1ps

module tb_frame_animation_sequencer_core;
  import fas_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               ended;
    logic               backward;
    logic [POS_W-1:0]   pos;
  } status_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fas_in_if  in_if();
  fas_out_if out_if();

  frame_animation_sequencer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if.sink),
    .out_chan  (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Sequencer state as the block should hold it
  logic [DURATION_BITS-1:0] durations [MAX_FRAMES];
  logic [POS_W-1:0]         position;
  logic [FRAME_W-1:0]       shown;
  logic                     backward;
  logic                     ended;
  logic [FC_W-1:0]          frame_cnt;
  mode_t                    end_mode;

  status_t status_q[$];
  int      mismatch_cnt;
  int      idle_cycles;
  bit      quiet;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic status_t step_sequencer(input op_t op, input logic [EIDX_W-1:0] idx,
                                             input logic [ETICK_W-1:0] ticks);
    int      n;
    int      total;
    int      i;
    bit      hit;
    status_t s;
    case (op)
      OP_TICK: begin
        n = (frame_cnt == 0) ? 1 : (frame_cnt > MAX_FRAMES) ? MAX_FRAMES : int'(frame_cnt);
        if (backward) begin
          if (position == 0) backward = 1'b0;
          else position = position - 1'b1;
        end else if (position != POS_MAX) begin
          position = position + 1'b1;
        end
        total = 0;
        hit = 1'b0;
        for (i = 0; i < n && !hit; i++) begin
          total += durations[i];
          if (position < total) begin
            shown = FRAME_W'(i);
            hit = 1'b1;
          end
        end
        if (!hit) begin
          if (total > POS_MAX) total = int'(POS_MAX);
          case (end_mode)
            MODE_PINGPONG: begin
              backward = 1'b1;
              position = POS_W'(total);
              shown = FRAME_W'(n - 1);
            end
            MODE_LOOP: begin
              position = '0;
              shown = '0;
            end
            MODE_ONCE: begin
              position = POS_W'(total);
              shown = FRAME_W'(n - 1);
              ended = 1'b1;
            end
            default: begin
              // stop: frame 0 shown, position keeps running
              shown = '0;
              ended = 1'b1;
            end
          endcase
        end
      end
      OP_RESTART: begin
        position = '0;
        shown = '0;
        ended = 1'b0;
        backward = 1'b0;
      end
      OP_WRITE: durations[idx] = ticks[DURATION_BITS-1:0];
      default: ;
    endcase
    s.frame = shown;
    s.ended = ended;
    s.backward = backward;
    s.pos = position;
    return s;
  endfunction

  task automatic send_item(input op_t op, input logic [EIDX_W-1:0] idx,
                           input logic [ETICK_W-1:0] ticks);
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 6) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.opcode = op;
    in_if.entry_index = idx;
    in_if.entry_ticks = ticks;
    do @(posedge clk); while (!in_if.ready);
    status_q.push_back(step_sequencer(op, idx, ticks));
  endtask

  task automatic tick(input int count);
    repeat (count) send_item(OP_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
  endtask

  // Drop valid and let every pending result drain
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic configure(input logic [FC_W-1:0] fc, input mode_t m);
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word = CFG_DATA_W'($urandom());
    mode_word[MODE_W-1:0] = m;
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_FRAME_COUNT;
    cfg_data = fc;
    @(negedge clk);
    cfg_index = CFG_END_MODE;
    cfg_data = mode_word;
    @(negedge clk);
    cfg_we = 1'b0;
    frame_cnt = fc;
    end_mode = m;
  endtask

  task automatic test_basic_ops();
    send_item(OP_RESTART, 4'd0, 8'd0);
    send_item(OP_NOP, 4'd15, 8'd255);
    send_item(OP_WRITE, 4'd0, 8'd2);
    send_item(OP_WRITE, 4'd1, 8'd1);
    send_item(OP_WRITE, 4'd2, 8'd0);
    send_item(OP_WRITE, 4'd15, 8'd255);
  endtask

  // Total of 7 ticks: turns at the end, walks back, reverse clears at zero
  task automatic test_pingpong_turn();
    wait_idle();
    configure(5'd2, MODE_PINGPONG);
    tick(7);
  endtask

  task automatic test_once_hold();
    wait_idle();
    configure(5'd2, MODE_ONCE);
    send_item(OP_RESTART, 4'd0, 8'd0);
    tick(4);
    send_item(OP_RESTART, 4'd0, 8'd0);
  endtask

  // frame_count 0 acts as one frame
  task automatic test_stop_mode();
    wait_idle();
    configure(5'd0, MODE_STOP);
    tick(3);
  endtask

  task automatic test_random_phases(input int phases, input int items);
    logic [FC_W-1:0] fc_pick [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd8};
    logic [FC_W-1:0] fc;
    mode_t           m;
    int              r;
    for (int ph = 0; ph < phases; ph++) begin
      wait_idle();
      fc = (ph < 6) ? fc_pick[ph] : FC_W'($urandom_range(31));
      m = (ph < 8) ? mode_t'(ph % 4) : mode_t'($urandom_range(3));
      configure(fc, m);
      quiet = (ph == 5);
      // mostly short frames so the ends get reached often
      for (int e = 0; e < MAX_FRAMES; e++)
        send_item(OP_WRITE, e[EIDX_W-1:0], ($urandom_range(15) == 0) ?
                  8'($urandom_range(255)) : 8'($urandom_range(4)));
      send_item(OP_RESTART, 4'($urandom_range(15)), 8'($urandom_range(255)));
      repeat (items) begin
        r = $urandom_range(99);
        if (r < 84) tick(1);
        else if (r < 89) send_item(OP_RESTART, 4'($urandom_range(15)), 8'($urandom_range(255)));
        else if (r < 95) send_item(OP_WRITE, 4'($urandom_range(15)), ($urandom_range(3) == 0) ?
                                   8'($urandom_range(255)) : 8'($urandom_range(5)));
        else send_item(OP_NOP, 4'($urandom_range(15)), 8'($urandom_range(255)));
      end
      quiet = 1'b0;
    end
  endtask

  always @(negedge clk) out_if.ready = quiet || ($urandom_range(99) >= 6);

  always @(posedge clk) begin
    status_t want;
    status_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.current_frame, out_if.anim_ended, out_if.playing_backward,
             out_if.tick_position};
      if (status_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: frame=%0d ended=%0b back=%0b pos=%0d",
                   got.frame, got.ended, got.backward, got.pos);
      end else begin
        want = status_q.pop_front();
        if (got.frame !== want.frame || got.ended !== want.ended ||
            got.backward !== want.backward || got.pos !== want.pos) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"status mismatch: exp frame=%0d ended=%0b back=%0b pos=%0d,",
                      " got frame=%0d ended=%0b back=%0b pos=%0d"},
                     want.frame, want.ended, want.backward, want.pos,
                     got.frame, got.ended, got.backward, got.pos);
        end
      end
    end
  end

  // Counts cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_frame_animation_sequencer_core failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_NOP;
    in_if.entry_index = '0;
    in_if.entry_ticks = '0;
    out_if.ready = 1'b0;
    quiet = 1'b0;
    position = '0;
    shown = '0;
    backward = 1'b0;
    ended = 1'b0;
    frame_cnt = 5'd1;
    end_mode = MODE_LOOP;
    foreach (durations[i]) durations[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_ops();
    test_pingpong_turn();
    test_once_hold();
    test_stop_mode();
    test_random_phases(13, 130);

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && status_q.size() == 0) begin
      $display("tb_frame_animation_sequencer_core passed");
    end else begin
      $display("tb_frame_animation_sequencer_core failed");
    end
    $finish;
  end

endmodule
